// ----- rtl/kf_smp_pkg.sv -----
package kf_smp_pkg;

   localparam int MAX_KEYS_DEF = 32;

   localparam int KEY_IDX_W  = 5;
   localparam int CNT_W      = 6;
   localparam int TIME_W     = 32;
   localparam int VAL_W      = 32;
   localparam int STAT_W     = 2;
   localparam int NUM_COMP   = 3;
   localparam int FRAC_W     = 16;
   localparam int QUOT_W     = TIME_W + FRAC_W;
   localparam int DIV_CNT_W  = 6;
   localparam int CHUNK_W    = 16;
   localparam int NUM_CHUNKS = QUOT_W / CHUNK_W;
   localparam int DELTA_W    = VAL_W + 1;
   localparam int PP_W       = DELTA_W + CHUNK_W;
   localparam int PROD_W     = DELTA_W + QUOT_W;
   localparam int PROD_LIM_B = 62;
   localparam int TERM_W     = PROD_LIM_B + 1 - FRAC_W;
   localparam int SUM_W      = 49;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
   localparam logic [STAT_W-1:0] ST_EQUAL_TIMES = 2'd1;
   localparam logic [STAT_W-1:0] ST_SATURATED   = 2'd2;

   localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_FETCH,
      S_CHECK,
      S_DIV,
      S_MUL,
      S_FIN,
      S_DONE
   } kfs_state_type;

endpackage

// ----- rtl/vec3_keyframe_track_sampler_unit.sv -----
// Keyframe track sampler for a three-component track in fixed point. A load word
// (req_opcode 0) writes one key at the accepting edge and leaves busy low, so the
// next word can follow at once; it gives no result. A sample word raises busy and,
// when done, drives rsp_valid for exactly one cycle with the result; the receiver
// cannot hold it off, so it must take the word in that cycle. A sample with one key
// in use passes from the accepting edge through the fetch, check and done states to
// rsp_valid. Otherwise the key search does one memory read and one compare per key
// tested (up to key_count-1 keys), then fetches both keys, runs the radix-2 divider
// for the factor, uses the shared 33x16 multiplier (three partial products plus one
// finish step per component) and issues the result. Equal key times skip the divide
// and multiply. The key store has no reset; sample only keys that were loaded.
module vec3_keyframe_track_sampler_unit #(
   parameter int MAX_KEYS = kf_smp_pkg::MAX_KEYS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [kf_smp_pkg::KEY_IDX_W-1:0]      req_key_index,
   input  logic [kf_smp_pkg::TIME_W-1:0]         req_time_stamp,
   input  logic signed [kf_smp_pkg::VAL_W-1:0]   req_value_x,
   input  logic signed [kf_smp_pkg::VAL_W-1:0]   req_value_y,
   input  logic signed [kf_smp_pkg::VAL_W-1:0]   req_value_z,
   output logic                                  rsp_valid,
   output logic signed [kf_smp_pkg::VAL_W-1:0]   rsp_out_x,
   output logic signed [kf_smp_pkg::VAL_W-1:0]   rsp_out_y,
   output logic signed [kf_smp_pkg::VAL_W-1:0]   rsp_out_z,
   output logic [kf_smp_pkg::STAT_W-1:0]         rsp_status,
   input  logic                                  csr_wr_en,
   input  logic [kf_smp_pkg::CNT_W-1:0]          csr_wr_data
);

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int VW    = kf_smp_pkg::VAL_W;
   localparam int TW    = kf_smp_pkg::TIME_W;
   localparam int NC    = kf_smp_pkg::NUM_COMP;
   localparam int ROW_W = NC * VW;

   kf_smp_pkg::kfs_state_type state_ff, state_in;

   logic [kf_smp_pkg::CNT_W-1:0] key_count_ff;
   logic [kf_smp_pkg::CNT_W-1:0] n_clamp;
   logic [kf_smp_pkg::CNT_W-1:0] n_ff;
   logic [TW-1:0]                query_ff;
   logic [AW-1:0]                idx_ff;
   logic [AW-1:0]                a_ff;
   logic                         one_ff;
   logic                         accept;

   // key store
   logic [TW-1:0]    key_time_mem [MAX_KEYS];
   logic [ROW_W-1:0] key_val_mem  [MAX_KEYS];
   logic [AW-1:0]    rd_a_addr, rd_b_addr;
   logic [TW-1:0]    time_a_q_ff, time_b_q_ff;
   logic [ROW_W-1:0] val_a_q_ff, val_b_q_ff;

   // divider
   logic [TW-1:0]                      rem_ff;
   logic [kf_smp_pkg::QUOT_W-1:0]      quot_ff;
   logic [TW-1:0]                      den_ff;
   logic [kf_smp_pkg::DIV_CNT_W-1:0]   div_cnt_ff;
   logic                               f_neg_ff;
   logic [TW:0]                        rem_sh;
   logic                               div_ge;
   logic [TW-1:0]                      rem_in;

   // multiplier and accumulate
   logic [kf_smp_pkg::DELTA_W-1:0] delta_mag_ff [NC];
   logic                           delta_neg_ff [NC];
   logic signed [VW-1:0]           val_a_ff     [NC];
   logic [1:0]                     comp_ff;
   logic [1:0]                     chunk_ff;
   logic [kf_smp_pkg::PROD_W-1:0]  acc_ff;
   logic [kf_smp_pkg::PROD_W-1:0]  acc_in;
   logic [kf_smp_pkg::CHUNK_W-1:0] f_chunk;
   logic [kf_smp_pkg::PP_W-1:0]    pp;
   logic signed [VW-1:0]           res_ff [NC];
   logic [kf_smp_pkg::STAT_W-1:0]  status_ff;

   // check step
   logic                           dt_zero, dt_neg, d_neg;
   logic [TW-1:0]                  dt_mag, d_mag;
   logic [kf_smp_pkg::DELTA_W-1:0] delta_mag [NC];
   logic                           delta_neg [NC];
   logic signed [kf_smp_pkg::DELTA_W-1:0] delta_diff [NC];

   // finish step
   logic                                 fin_neg, fin_over, fin_sat;
   logic [kf_smp_pkg::TERM_W-1:0]        term_mag;
   logic signed [kf_smp_pkg::SUM_W-1:0]  term_s, sum_s, va_ext;
   logic signed [VW-1:0]                 fin_res;

   logic scan_hit, scan_last, div_last, chunk_last, comp_last;

   logic                rsp_valid_ff;
   logic signed [VW-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [kf_smp_pkg::STAT_W-1:0] rsp_status_ff;

   assign accept = start && !busy;

   // key count in use: zero means one, capped at the store depth
   always_comb begin
      if (key_count_ff == '0) begin
         n_clamp = kf_smp_pkg::CNT_W'(1);
      end else if (32'(key_count_ff) > MAX_KEYS) begin
         n_clamp = kf_smp_pkg::CNT_W'(MAX_KEYS);
      end else begin
         n_clamp = key_count_ff;
      end
   end

   assign scan_hit   = query_ff < time_a_q_ff;
   assign scan_last  = (32'(idx_ff) + 32'd2) >= 32'(n_ff);
   assign dt_zero    = time_a_q_ff == time_b_q_ff;
   assign div_last   = div_cnt_ff == kf_smp_pkg::DIV_CNT_W'(kf_smp_pkg::QUOT_W - 1);
   assign chunk_last = chunk_ff == 2'(kf_smp_pkg::NUM_CHUNKS - 1);
   assign comp_last  = comp_ff == 2'(NC - 1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kf_smp_pkg::S_IDLE: begin
            if (accept && req_opcode == kf_smp_pkg::OP_SAMPLE) begin
               state_in = (n_clamp == kf_smp_pkg::CNT_W'(1)) ? kf_smp_pkg::S_FETCH
                                                             : kf_smp_pkg::S_SCAN_RD;
            end
         end
         kf_smp_pkg::S_SCAN_RD:  state_in = kf_smp_pkg::S_SCAN_CMP;
         kf_smp_pkg::S_SCAN_CMP: begin
            state_in = (scan_hit || scan_last) ? kf_smp_pkg::S_FETCH : kf_smp_pkg::S_SCAN_RD;
         end
         kf_smp_pkg::S_FETCH: state_in = kf_smp_pkg::S_CHECK;
         kf_smp_pkg::S_CHECK: begin
            state_in = (one_ff || dt_zero) ? kf_smp_pkg::S_DONE : kf_smp_pkg::S_DIV;
         end
         kf_smp_pkg::S_DIV: if (div_last) state_in = kf_smp_pkg::S_MUL;
         kf_smp_pkg::S_MUL: if (chunk_last) state_in = kf_smp_pkg::S_FIN;
         kf_smp_pkg::S_FIN: begin
            state_in = comp_last ? kf_smp_pkg::S_DONE : kf_smp_pkg::S_MUL;
         end
         kf_smp_pkg::S_DONE: state_in = kf_smp_pkg::S_IDLE;
         default: state_in = kf_smp_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      busy      = state_ff != kf_smp_pkg::S_IDLE;
      rd_a_addr = (state_ff == kf_smp_pkg::S_SCAN_RD) ? idx_ff + AW'(1) : a_ff;
      rd_b_addr = a_ff + AW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kf_smp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kf_smp_pkg::CNT_W'(1);
      end else if (csr_wr_en) begin
         key_count_ff <= csr_wr_data;
      end
   end

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (accept && req_opcode == kf_smp_pkg::OP_LOAD && 32'(req_key_index) < MAX_KEYS) begin
         key_time_mem[AW'(req_key_index)] <= req_time_stamp;
         key_val_mem[AW'(req_key_index)]  <= {req_value_z, req_value_y, req_value_x};
      end
      time_a_q_ff <= key_time_mem[rd_a_addr];
      time_b_q_ff <= key_time_mem[rd_b_addr];
      val_a_q_ff  <= key_val_mem[rd_a_addr];
      val_b_q_ff  <= key_val_mem[rd_b_addr];
   end

   // segment setup: signed time differences as sign and magnitude
   always_comb begin
      dt_neg = time_b_q_ff < time_a_q_ff;
      dt_mag = dt_neg ? time_a_q_ff - time_b_q_ff : time_b_q_ff - time_a_q_ff;
      d_neg  = query_ff < time_a_q_ff;
      d_mag  = d_neg ? time_a_q_ff - query_ff : query_ff - time_a_q_ff;
      for (int c = 0; c < NC; c++) begin
         delta_diff[c] = $signed({val_b_q_ff[c*VW + VW - 1], val_b_q_ff[c*VW +: VW]})
                       - $signed({val_a_q_ff[c*VW + VW - 1], val_a_q_ff[c*VW +: VW]});
         delta_neg[c]  = delta_diff[c][kf_smp_pkg::DELTA_W-1];
         delta_mag[c]  = delta_neg[c] ? kf_smp_pkg::DELTA_W'(-delta_diff[c])
                                      : kf_smp_pkg::DELTA_W'(delta_diff[c]);
      end
   end

   // restoring divider, one quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quot_ff[kf_smp_pkg::QUOT_W-1]};
      div_ge = rem_sh >= {1'b0, den_ff};
      rem_in = div_ge ? TW'(rem_sh - {1'b0, den_ff}) : TW'(rem_sh);
   end

   // |delta| times one 16-bit slice of |f|, added in at the slice's weight
   always_comb begin
      case (chunk_ff)
         2'd0:    f_chunk = quot_ff[0 +: kf_smp_pkg::CHUNK_W];
         2'd1:    f_chunk = quot_ff[kf_smp_pkg::CHUNK_W +: kf_smp_pkg::CHUNK_W];
         default: f_chunk = quot_ff[2*kf_smp_pkg::CHUNK_W +: kf_smp_pkg::CHUNK_W];
      endcase
      pp = {{kf_smp_pkg::CHUNK_W{1'b0}}, delta_mag_ff[comp_ff]}
         * {{kf_smp_pkg::DELTA_W{1'b0}}, f_chunk};
      case (chunk_ff)
         2'd0:    acc_in = acc_ff + kf_smp_pkg::PROD_W'(pp);
         2'd1:    acc_in = acc_ff + (kf_smp_pkg::PROD_W'(pp) << kf_smp_pkg::CHUNK_W);
         default: acc_in = acc_ff + (kf_smp_pkg::PROD_W'(pp) << (2*kf_smp_pkg::CHUNK_W));
      endcase
   end

   // product limit, truncation toward zero and final saturation
   always_comb begin
      fin_neg  = delta_neg_ff[comp_ff] ^ f_neg_ff;
      fin_over = acc_ff > (kf_smp_pkg::PROD_W'(1) << kf_smp_pkg::PROD_LIM_B);
      term_mag = acc_ff[kf_smp_pkg::PROD_LIM_B:kf_smp_pkg::FRAC_W];
      term_s   = $signed({{(kf_smp_pkg::SUM_W - kf_smp_pkg::TERM_W){1'b0}}, term_mag});
      if (fin_neg) begin
         term_s = -term_s;
      end
      va_ext = $signed({{(kf_smp_pkg::SUM_W - VW){val_a_ff[comp_ff][VW-1]}},
                        val_a_ff[comp_ff]});
      sum_s  = va_ext + term_s;
      if (fin_over) begin
         fin_sat = 1'b1;
         fin_res = fin_neg ? kf_smp_pkg::Q_MIN : kf_smp_pkg::Q_MAX;
      end else if (sum_s > kf_smp_pkg::SUM_W'(kf_smp_pkg::Q_MAX)) begin
         fin_sat = 1'b1;
         fin_res = kf_smp_pkg::Q_MAX;
      end else if (sum_s < kf_smp_pkg::SUM_W'(kf_smp_pkg::Q_MIN)) begin
         fin_sat = 1'b1;
         fin_res = kf_smp_pkg::Q_MIN;
      end else begin
         fin_sat = 1'b0;
         fin_res = VW'(sum_s);
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         kf_smp_pkg::S_IDLE: begin
            if (accept && req_opcode == kf_smp_pkg::OP_SAMPLE) begin
               query_ff <= req_time_stamp;
               n_ff     <= n_clamp;
               idx_ff   <= '0;
               a_ff     <= '0;
               one_ff   <= n_clamp == kf_smp_pkg::CNT_W'(1);
            end
         end
         kf_smp_pkg::S_SCAN_CMP: begin
            if (scan_hit) begin
               a_ff <= idx_ff;
            end else if (scan_last) begin
               // no match: fall back to the first segment
               a_ff <= '0;
            end else begin
               idx_ff <= idx_ff + AW'(1);
            end
         end
         kf_smp_pkg::S_CHECK: begin
            for (int c = 0; c < NC; c++) begin
               val_a_ff[c]     <= $signed(val_a_q_ff[c*VW +: VW]);
               res_ff[c]       <= $signed(val_a_q_ff[c*VW +: VW]);
               delta_mag_ff[c] <= delta_mag[c];
               delta_neg_ff[c] <= delta_neg[c];
            end
            status_ff  <= (!one_ff && dt_zero) ? kf_smp_pkg::ST_EQUAL_TIMES : kf_smp_pkg::ST_OK;
            rem_ff     <= '0;
            quot_ff    <= {d_mag, {kf_smp_pkg::FRAC_W{1'b0}}};
            den_ff     <= dt_mag;
            f_neg_ff   <= d_neg ^ dt_neg;
            div_cnt_ff <= '0;
            comp_ff    <= '0;
            chunk_ff   <= '0;
            acc_ff     <= '0;
         end
         kf_smp_pkg::S_DIV: begin
            rem_ff     <= rem_in;
            quot_ff    <= {quot_ff[kf_smp_pkg::QUOT_W-2:0], div_ge};
            div_cnt_ff <= div_cnt_ff + kf_smp_pkg::DIV_CNT_W'(1);
         end
         kf_smp_pkg::S_MUL: begin
            acc_ff   <= acc_in;
            chunk_ff <= chunk_ff + 2'd1;
         end
         kf_smp_pkg::S_FIN: begin
            res_ff[comp_ff] <= fin_res;
            if (fin_sat) begin
               status_ff <= kf_smp_pkg::ST_SATURATED;
            end
            comp_ff  <= comp_ff + 2'd1;
            chunk_ff <= '0;
            acc_ff   <= '0;
         end
         default: ;
      endcase
   end

   // result word, one cycle strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= state_ff == kf_smp_pkg::S_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == kf_smp_pkg::S_DONE) begin
         rsp_x_ff      <= res_ff[0];
         rsp_y_ff      <= res_ff[1];
         rsp_z_ff      <= res_ff[2];
         rsp_status_ff <= status_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_x_ff;
   assign rsp_out_y  = rsp_y_ff;
   assign rsp_out_z  = rsp_z_ff;
   assign rsp_status = rsp_status_ff;

   a_load_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == kf_smp_pkg::OP_LOAD) |=> !busy)
      else $error("load word left the unit busy");

   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == kf_smp_pkg::OP_SAMPLE) |=> busy)
      else $error("sample word not taken up");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a sample in flight");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule
